### rtl/slot_allocator_with_scan_core_defines.svh
// Assertion macros shared by the slot allocator checker.
// No dependencies; included by the files that assert.
`ifndef SLOT_ALLOCATOR_WITH_SCAN_CORE_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_SCAN_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SALLOC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("slot allocator assertion failed");

// Check a property on every clock edge, reset included.
`define SALLOC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("slot allocator reset assertion failed");

`endif

### rtl/salloc_pkg.sv
// Shared types, codes and constants for the slot allocator.
// No dependencies; used by every RTL file of the block.
package salloc_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_IDX_W    = 4;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_SCAN    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_NO_VACANCY    = 3'd1,
        ST_RELEASED      = 3'd2,
        ST_BAD_INDEX     = 3'd3,
        ST_ALREADY_EMPTY = 3'd4,
        ST_SCAN_ENTRY    = 3'd5,
        ST_SCAN_NONE     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_REL_CHECK,
        S_REL_EMIT,
        S_SCAN_SEEK,
        S_SCAN_LOAD
    } state_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [15:0]           worker_tag;
        logic [31:0]           salary;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [15:0]           worker_tag_out;
        logic [31:0]           salary_out;
        logic                  last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    ptr_inc;
        logic    alloc_commit;
        logic    rel_commit;
        logic    pend_load;
        logic    emit;
        status_t emit_status;
        logic    emit_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] in_mode;
        logic       ptr_in_range;
        logic       occ_at_ptr;
        logic       idx_bad;
        logic       occ_at_idx;
        logic       out_free;
        logic       have_pend;
    } sts_t;

endpackage

### rtl/salloc_dp.sv
// Datapath of the slot allocator: request capture, slot pointer, occupancy
// bits, tag and salary memories, scan hold entry and output register.
// Depends on salloc_pkg.
module salloc_dp #(
    parameter int SLOTS = salloc_pkg::SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  salloc_pkg::req_t                  s_data,
    input  logic                              cfg_we,
    input  logic [salloc_pkg::CFG_W-1:0]      cfg_wdata,
    input  salloc_pkg::cmd_t                  cmd,
    output salloc_pkg::sts_t                  sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output salloc_pkg::rsp_t                  m_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > salloc_pkg::SLOT_IDX_W) ? CNT_W : salloc_pkg::SLOT_IDX_W;
    localparam int IW     = salloc_pkg::SLOT_IDX_W;

    logic [salloc_pkg::CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0]             n_cnt;

    logic [1:0]       mode_reg;
    logic [IW-1:0]    idx_reg;
    logic [15:0]      tag_reg;
    logic [31:0]      sal_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [SLOTS-1:0] occ_reg;

    logic          have_pend_reg;
    logic [IW-1:0] pend_slot_reg;
    logic [15:0]   pend_tag_reg;
    logic [31:0]   pend_sal_reg;

    logic [15:0] tag_mem [SLOTS];
    logic [31:0] sal_mem [SLOTS];
    logic [15:0] rd_tag_reg;
    logic [31:0] rd_sal_reg;

    logic             out_valid_reg;
    salloc_pkg::rsp_t out_reg;
    salloc_pkg::rsp_t rsp_next;

    logic [SLOT_W-1:0] ptr_addr;
    logic [SLOT_W-1:0] idx_addr;
    logic [SLOT_W-1:0] rd_addr;

    // Saturate the enabled count at the table size
    always_comb begin
        if (32'(cfg_reg) > SLOTS) begin
            n_cnt = CNT_W'(SLOTS);
        end else begin
            n_cnt = CNT_W'(cfg_reg);
        end
    end

    assign ptr_addr = ptr_reg[SLOT_W-1:0];
    assign idx_addr = SLOT_W'(idx_reg);
    assign rd_addr  = (mode_reg == salloc_pkg::MODE_RELEASE) ? idx_addr : ptr_addr;

    assign sts.in_mode      = s_data.mode;
    assign sts.ptr_in_range = ptr_reg < n_cnt;
    assign sts.occ_at_ptr   = occ_reg[ptr_addr];
    assign sts.idx_bad      = CMP_W'(idx_reg) >= CMP_W'(n_cnt);
    assign sts.occ_at_idx   = occ_reg[idx_addr];
    assign sts.out_free     = !out_valid_reg || m_ready;
    assign sts.have_pend    = have_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= salloc_pkg::CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_data.mode;
            idx_reg  <= s_data.slot_index;
            tag_reg  <= s_data.worker_tag;
            sal_reg  <= s_data.salary;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            occ_reg       <= '0;
            have_pend_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                ptr_reg       <= '0;
                have_pend_reg <= 1'b0;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.pend_load) begin
                have_pend_reg <= 1'b1;
            end
            if (cmd.alloc_commit) begin
                occ_reg[ptr_addr] <= 1'b1;
            end
            if (cmd.rel_commit) begin
                occ_reg[idx_addr] <= 1'b0;
            end
        end
    end

    // Hold the last occupied slot found until the next one shows whether it is final
    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_slot_reg <= IW'(ptr_reg);
            pend_tag_reg  <= rd_tag_reg;
            pend_sal_reg  <= rd_sal_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc_commit) begin
            tag_mem[ptr_addr] <= tag_reg;
            sal_mem[ptr_addr] <= sal_reg;
        end
        rd_tag_reg <= tag_mem[rd_addr];
        rd_sal_reg <= sal_mem[rd_addr];
    end

    always_comb begin
        rsp_next                = '0;
        rsp_next.status         = cmd.emit_status;
        rsp_next.last           = cmd.emit_last;
        case (cmd.emit_status)
            salloc_pkg::ST_ALLOCATED: begin
                rsp_next.slot = IW'(ptr_reg);
            end
            salloc_pkg::ST_RELEASED: begin
                rsp_next.slot           = idx_reg;
                rsp_next.worker_tag_out = rd_tag_reg;
            end
            salloc_pkg::ST_BAD_INDEX,
            salloc_pkg::ST_ALREADY_EMPTY: begin
                rsp_next.slot = idx_reg;
            end
            salloc_pkg::ST_SCAN_ENTRY: begin
                rsp_next.slot           = pend_slot_reg;
                rsp_next.worker_tag_out = pend_tag_reg;
                rsp_next.salary_out     = pend_sal_reg;
            end
            default: begin
                rsp_next.slot = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= rsp_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/salloc_ctrl.sv
// Controller of the slot allocator: sequences allocate, release and scan.
// Depends on salloc_pkg; drives the datapath by command word.
module salloc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  salloc_pkg::sts_t sts,
    output salloc_pkg::cmd_t cmd
);

    salloc_pkg::state_t state_reg;
    salloc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= salloc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            salloc_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (sts.in_mode)
                        salloc_pkg::MODE_ALLOC:   state_next = salloc_pkg::S_ALLOC;
                        salloc_pkg::MODE_RELEASE: state_next = salloc_pkg::S_REL_CHECK;
                        salloc_pkg::MODE_SCAN:    state_next = salloc_pkg::S_SCAN_SEEK;
                        default:                  state_next = salloc_pkg::S_IDLE;
                    endcase
                end
            end
            salloc_pkg::S_ALLOC: begin
                if (!(sts.ptr_in_range && sts.occ_at_ptr) && sts.out_free) begin
                    state_next = salloc_pkg::S_IDLE;
                end
            end
            salloc_pkg::S_REL_CHECK: begin
                if (sts.idx_bad || !sts.occ_at_idx) begin
                    if (sts.out_free) begin
                        state_next = salloc_pkg::S_IDLE;
                    end
                end else begin
                    state_next = salloc_pkg::S_REL_EMIT;
                end
            end
            salloc_pkg::S_REL_EMIT: begin
                if (sts.out_free) begin
                    state_next = salloc_pkg::S_IDLE;
                end
            end
            salloc_pkg::S_SCAN_SEEK: begin
                if (!sts.ptr_in_range) begin
                    if (sts.out_free) begin
                        state_next = salloc_pkg::S_IDLE;
                    end
                end else if (sts.occ_at_ptr) begin
                    if (!sts.have_pend || sts.out_free) begin
                        state_next = salloc_pkg::S_SCAN_LOAD;
                    end
                end
            end
            salloc_pkg::S_SCAN_LOAD: begin
                state_next = salloc_pkg::S_SCAN_SEEK;
            end
            default: begin
                state_next = salloc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.emit_status = salloc_pkg::ST_ALLOCATED;
        cmd.emit_last   = 1'b1;
        s_ready         = 1'b0;
        case (state_reg)
            salloc_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            salloc_pkg::S_ALLOC: begin
                if (sts.ptr_in_range && sts.occ_at_ptr) begin
                    cmd.ptr_inc = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.ptr_in_range) begin
                        cmd.emit_status  = salloc_pkg::ST_ALLOCATED;
                        cmd.alloc_commit = 1'b1;
                    end else begin
                        cmd.emit_status = salloc_pkg::ST_NO_VACANCY;
                    end
                end
            end
            salloc_pkg::S_REL_CHECK: begin
                if (sts.idx_bad) begin
                    cmd.emit        = sts.out_free;
                    cmd.emit_status = salloc_pkg::ST_BAD_INDEX;
                end else if (!sts.occ_at_idx) begin
                    cmd.emit        = sts.out_free;
                    cmd.emit_status = salloc_pkg::ST_ALREADY_EMPTY;
                end
            end
            salloc_pkg::S_REL_EMIT: begin
                cmd.emit        = sts.out_free;
                cmd.rel_commit  = sts.out_free;
                cmd.emit_status = salloc_pkg::ST_RELEASED;
            end
            salloc_pkg::S_SCAN_SEEK: begin
                if (!sts.ptr_in_range) begin
                    cmd.emit        = sts.out_free;
                    cmd.emit_status = sts.have_pend ? salloc_pkg::ST_SCAN_ENTRY
                                                    : salloc_pkg::ST_SCAN_NONE;
                end else if (sts.occ_at_ptr) begin
                    // flush the held entry, it is not the final one
                    cmd.emit        = sts.have_pend && sts.out_free;
                    cmd.emit_status = salloc_pkg::ST_SCAN_ENTRY;
                    cmd.emit_last   = 1'b0;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            salloc_pkg::S_SCAN_LOAD: begin
                cmd.pend_load = 1'b1;
                cmd.ptr_inc   = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/slot_allocator_with_scan_core.sv
// Top level of the slot allocator: controller plus datapath.
// Depends on salloc_pkg, salloc_ctrl and salloc_dp.
//
//   channel  | handshake         | word
//   ---------+-------------------+-------------------------------
//   request  | s_valid / s_ready | salloc_pkg::req_t (s_data)
//   result   | m_valid / m_ready | salloc_pkg::rsp_t (m_data)
//   config   | cfg_we            | cfg_wdata, enabled slot count
//
// A pointer walks the table from slot 0. Allocate steps past occupied slots to
// the lowest free one, or past all enabled ones on no vacancy; release checks
// index and occupancy before it returns the tag. Scan holds each occupied slot.
// The next request is taken the cycle after the final result is registered.
// Reset clears occupancy and the pending result; slot memories are not cleared.
// A stalled result holds the walk at the next emission point.
module slot_allocator_with_scan_core #(
    parameter int SLOTS = salloc_pkg::SLOTS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  salloc_pkg::req_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output salloc_pkg::rsp_t             m_data,
    input  logic                         cfg_we,
    input  logic [salloc_pkg::CFG_W-1:0] cfg_wdata
);

    salloc_pkg::cmd_t cmd;
    salloc_pkg::sts_t sts;

    salloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    salloc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/salloc_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on salloc_pkg and slot_allocator_with_scan_core_defines.svh.
`include "slot_allocator_with_scan_core_defines.svh"

module salloc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input salloc_pkg::req_t s_data,
    input logic             m_valid,
    input logic             m_ready,
    input salloc_pkg::rsp_t m_data
);

    logic out_stalled;
    logic req_taken;
    logic non_final;

    assign out_stalled = m_valid && !m_ready;
    assign req_taken   = s_valid && s_ready &&
                         (s_data.mode == salloc_pkg::MODE_ALLOC ||
                          s_data.mode == salloc_pkg::MODE_RELEASE ||
                          s_data.mode == salloc_pkg::MODE_SCAN);
    assign non_final   = m_valid && !m_data.last;

    // stalled result word holds
    `SALLOC_ASSERT(a_out_hold, aclk, aresetn, out_stalled |=> (m_valid && $stable(m_data)))

    // after reset nothing is pending and a request can be taken
    `SALLOC_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> (!m_valid && s_ready))

    // a real request closes the input until its results are out
    `SALLOC_ASSERT(a_busy_after_req, aclk, aresetn, req_taken |=> !s_ready)

    // only scan entries may be non-final
    `SALLOC_ASSERT(a_last_scan_only, aclk, aresetn, non_final |-> (m_data.status == salloc_pkg::ST_SCAN_ENTRY))

endmodule

bind slot_allocator_with_scan_core salloc_checker u_salloc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
